// ===== rtl/core/bhq_pkg.sv =====
`timescale 1ns / 1ps
package bhq_pkg;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] key;
    logic [15:0] tag;
  } in_word_t;

  typedef struct packed {
    logic [15:0] min_key;
    logic [15:0] min_tag;
    logic [6:0]  occupancy;
    logic        is_empty;
    logic        push_dropped;
  } out_word_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_PLACE,
    ST_POP_LD,
    ST_DOWN,
    ST_ROOT,
    ST_DONE
  } st_t;

endpackage

// ===== rtl/core/bhq_mem.sv =====
`timescale 1ns / 1ps
module bhq_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  bhq_pkg::entry_t  wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output bhq_pkg::entry_t  rdata_a,
  output bhq_pkg::entry_t  rdata_b
);
  import bhq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/core/bhq_ctrl.sv =====
`timescale 1ns / 1ps
module bhq_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bhq_pkg::in_word_t  in_data,
  output logic               done_valid,
  input  logic               done_ready,
  output bhq_pkg::out_word_t done_data
);
  import bhq_pkg::*;

  st_t            state, state_next;
  logic [CW-1:0]  count, count_next;
  logic [AW-1:0]  pos, pos_next;
  entry_t         item, item_next;
  logic           dropped, dropped_next;

  logic           we;
  logic [AW-1:0]  waddr;
  entry_t         wdata;
  logic [AW-1:0]  raddr_a, raddr_b;
  entry_t         rdata_a, rdata_b;

  logic [AW+1:0]  lc_cur, rc_cur, lc_nxt, rc_nxt, n_ext;
  logic [AW-1:0]  ppos, gpos, cnt_par, best_idx;
  logic           take_l, take_r;
  entry_t         cand;

  bhq_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Index arithmetic for one level of the tree.
  assign lc_cur   = {1'b0, pos, 1'b0} + (AW+2)'(1);
  assign rc_cur   = {1'b0, pos, 1'b0} + (AW+2)'(2);
  assign n_ext    = (AW+2)'(count);
  assign ppos     = AW'((pos - AW'(1)) >> 1);
  assign gpos     = AW'((ppos - AW'(1)) >> 1);
  assign cnt_par  = AW'((count - CW'(1)) >> 1);

  // Child selection: left first, then right against the winner so far.
  assign take_l   = (lc_cur < n_ext) && (rdata_a.key < item.key);
  assign cand     = take_l ? rdata_a : item;
  assign take_r   = (rc_cur < n_ext) && (rdata_b.key < cand.key);
  assign best_idx = take_r ? rc_cur[AW-1:0] : lc_cur[AW-1:0];
  assign lc_nxt   = {1'b0, best_idx, 1'b0} + (AW+2)'(1);
  assign rc_nxt   = {1'b0, best_idx, 1'b0} + (AW+2)'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    item    <= item_next;
    dropped <= dropped_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    pos_next     = pos;
    item_next    = item;
    dropped_next = dropped;
    we           = 1'b0;
    waddr        = pos;
    wdata        = item;
    raddr_a      = '0;
    raddr_b      = '0;
    in_ready     = 1'b0;
    done_valid   = 1'b0;

    done_data.min_key      = (count == '0) ? 16'd0 : rdata_a.key;
    done_data.min_tag      = (count == '0) ? 16'd0 : rdata_a.tag;
    done_data.occupancy    = 7'(count);
    done_data.is_empty     = (count == '0);
    done_data.push_dropped = dropped;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dropped_next = 1'b0;
          if (in_data.op == OP_PUSH) begin
            if (count == CW'(CAPACITY)) begin
              dropped_next = 1'b1;
              state_next   = ST_ROOT;
            end else begin
              item_next  = '{key: in_data.key, tag: in_data.tag};
              pos_next   = AW'(count);
              count_next = count + CW'(1);
              if (count == '0) begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = '{key: in_data.key, tag: in_data.tag};
                state_next = ST_ROOT;
              end else begin
                raddr_a    = cnt_par;
                state_next = ST_UP;
              end
            end
          end else begin
            if (count == '0) begin
              state_next = ST_ROOT;
            end else begin
              // Fetch the last word; it becomes the new root.
              raddr_a    = AW'(count - CW'(1));
              count_next = count - CW'(1);
              state_next = (count == CW'(1)) ? ST_ROOT : ST_POP_LD;
            end
          end
        end
      end

      ST_UP: begin
        we = 1'b1;
        if (rdata_a.key > item.key) begin
          // Parent moves down into the hole; the hole moves up.
          wdata    = rdata_a;
          pos_next = ppos;
          if (ppos == '0) begin
            state_next = ST_UP_PLACE;
          end else begin
            raddr_a = gpos;
          end
        end else begin
          state_next = ST_ROOT;
        end
      end

      ST_UP_PLACE: begin
        we         = 1'b1;
        state_next = ST_ROOT;
      end

      ST_POP_LD: begin
        item_next  = rdata_a;
        pos_next   = '0;
        raddr_a    = AW'(1);
        raddr_b    = AW'(2);
        state_next = ST_DOWN;
      end

      ST_DOWN: begin
        we = 1'b1;
        if (take_l || take_r) begin
          wdata    = take_r ? rdata_b : rdata_a;
          pos_next = best_idx;
          raddr_a  = lc_nxt[AW-1:0];
          raddr_b  = rc_nxt[AW-1:0];
        end else begin
          state_next = ST_ROOT;
        end
      end

      ST_ROOT: begin
        state_next = ST_DONE;
      end

      ST_DONE: begin
        // The root read stays on address zero, so the data holds while stalled.
        done_valid = 1'b1;
        if (done_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/binary_min_heap_queue.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Word
// in        input      in_valid / in_ready   in_data  (op, key, tag)
// out       output     out_valid / out_ready out_data (min_key, min_tag, occupancy,
//                                                      is_empty, push_dropped)
//
// One word is in flight. A push moves the hole up level by level; a pop puts the last
// word into the root and sifts it down level by level; then the root is read. Dropped
// pushes, pushes into an empty heap and pops that leave or find it empty go straight to
// the root read. The next can be accepted at the edge after the result is registered.
// Reset clears the count and control only; the memory is never cleared. A finished word
// waits in the output register while the next is taken; a result stalls until it drains.
module binary_min_heap_queue #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bhq_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bhq_pkg::out_word_t out_data
);
  import bhq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic      done_valid, done_ready;
  out_word_t done_data;

  bhq_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done_data  (done_data)
  );

  assign done_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_valid && done_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      out_data <= done_data;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in progress");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_empty |->
      out_data.min_key == 16'd0 && out_data.min_tag == 16'd0 &&
      !out_data.push_dropped)
    else $error("empty heap reports a nonzero minimum or a drop");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.push_dropped |->
      out_data.occupancy == 7'(CAPACITY) && !out_data.is_empty)
    else $error("push dropped while heap not full");

endmodule
